@@ rtl/cml_pkg.sv @@
// shared types and constants for the piecewise-linear color map
package cml_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int POS_W          = 16;
    localparam int CH_W           = 8;
    localparam int NUM_CH         = 4;
    localparam int NPT_W          = 5;
    localparam int IDX_W          = 4;
    localparam int PROD_W         = CH_W + POS_W;
    localparam int DIVD_W         = PROD_W + 1;
    localparam int DIVS_W         = POS_W + 1;

    localparam logic [NPT_W-1:0] NPT_RESET = NPT_W'(2);

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef logic [CH_W-1:0] t_chan;
    typedef t_chan [NUM_CH-1:0] t_color;

    typedef struct packed {
        logic              req_type;
        logic [IDX_W-1:0]  point_index;
        logic [POS_W-1:0]  point_pos;
        t_color            color;
        logic [POS_W-1:0]  lookup_pos;
    } t_req;

    typedef struct packed {
        logic              valid;
        logic              degen;
        logic [POS_W-1:0]  num;
        logic [POS_W-1:0]  den;
        t_color            c0;
        t_color            c1;
    } t_seg;

    typedef struct packed {
        logic    valid;
        logic    degen;
        t_color  color;
    } t_res;

endpackage

@@ rtl/cml_ram.sv @@
// generic single-write single-read ram with registered read data
module cml_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/cml_seg.sv @@
// input stage, segment search, point read and weight clamp
module cml_seg
    import cml_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_req             i_req,
    input  logic [NPT_W-1:0] i_num_points,
    output t_seg             o_seg
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int EW = POS_W + CH_W * NUM_CH;

    logic                r_vld1;
    t_req                r_req1;
    logic [POS_W-1:0]    r_pos [0:MAX_POINTS-1];
    logic [NW-1:0]       c_n;
    logic                c_run;
    logic [IW-1:0]       c_idx;
    logic                c_wr;
    logic [IW-1:0]       c_waddr;
    logic [EW-1:0]       c_wdata;
    logic [EW-1:0]       w_rd_lo;
    logic [EW-1:0]       w_rd_hi;
    logic                r_vld2;
    logic [POS_W-1:0]    r_lpos2;
    logic signed [POS_W:0] c_num;
    logic signed [POS_W:0] c_den;
    logic                c_degen;
    logic [POS_W-1:0]    n_num;
    logic [POS_W-1:0]    n_den;
    t_seg                r_seg;

    always_comb begin
        if (int'(i_num_points) < 2) begin
            c_n = NW'(2);
        end else if (int'(i_num_points) > MAX_POINTS) begin
            c_n = NW'(MAX_POINTS);
        end else begin
            c_n = NW'(i_num_points);
        end
    end

    // walk: last leading point at or below the lookup position
    always_comb begin
        c_run = 1'b1;
        c_idx = '0;
        for (int k = 1; k <= MAX_POINTS - 2; k++) begin
            if (c_run && (k <= int'(c_n) - 2) && (r_pos[k] <= r_req1.lookup_pos)) begin
                c_idx = IW'(k);
            end else begin
                c_run = 1'b0;
            end
        end
    end

    assign c_wr    = i_en && r_vld1 && (r_req1.req_type == REQ_WRITE)
                     && (int'(r_req1.point_index) < MAX_POINTS);
    assign c_waddr = IW'(r_req1.point_index);
    assign c_wdata = {r_req1.point_pos, r_req1.color};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1 && (r_req1.req_type == REQ_LOOKUP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_req1  <= i_req;
            r_lpos2 <= r_req1.lookup_pos;
        end
        if (c_wr) begin
            r_pos[c_waddr] <= r_req1.point_pos;
        end
    end

    cml_ram #(.WIDTH(EW), .DEPTH(MAX_POINTS)) u_ram_lo (
        .i_clk   (i_clk),
        .i_we    (c_wr),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_re    (i_en),
        .i_raddr (c_idx),
        .o_rdata (w_rd_lo)
    );

    cml_ram #(.WIDTH(EW), .DEPTH(MAX_POINTS)) u_ram_hi (
        .i_clk   (i_clk),
        .i_we    (c_wr),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_re    (i_en),
        .i_raddr (c_idx + IW'(1)),
        .o_rdata (w_rd_hi)
    );

    always_comb begin
        c_num   = signed'({1'b0, r_lpos2}) - signed'({1'b0, w_rd_lo[EW-1 -: POS_W]});
        c_den   = signed'({1'b0, w_rd_hi[EW-1 -: POS_W]})
                  - signed'({1'b0, w_rd_lo[EW-1 -: POS_W]});
        c_degen = (c_den == '0);
        if (c_den < 0) begin
            c_den = -c_den;
            c_num = -c_num;
        end
        if (c_num < 0) begin
            c_num = '0;
        end
        if (c_num > c_den) begin
            c_num = c_den;
        end
        n_num = c_num[POS_W-1:0];
        n_den = c_den[POS_W-1:0];
        // zero-length segment: weight 0 over 1 gives the lower color
        if (c_degen) begin
            n_num = '0;
            n_den = POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg.valid <= 1'b0;
        end else if (i_en) begin
            r_seg.valid <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_seg.degen <= c_degen;
            r_seg.num   <= n_num;
            r_seg.den   <= n_den;
            r_seg.c0    <= w_rd_lo[CH_W*NUM_CH-1:0];
            r_seg.c1    <= w_rd_hi[CH_W*NUM_CH-1:0];
        end
    end

    assign o_seg = r_seg;

endmodule

@@ rtl/cml_blend.sv @@
// weighted sum per channel and pipelined rounding divide
module cml_blend
    import cml_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_seg i_seg,
    output t_res o_res
);

    localparam int QS = CH_W;

    logic                r_mvld;
    logic                r_mdeg;
    logic [POS_W-1:0]    r_mden;
    logic [PROD_W-1:0]   r_prod [0:NUM_CH-1];
    logic [POS_W-1:0]    c_inv;

    logic                r_vld [0:QS-1];
    logic                r_deg [0:QS-1];
    logic [DIVS_W-1:0]   r_dvs [0:QS-1];
    logic [DIVD_W-1:0]   r_rem [0:QS-1][0:NUM_CH-1];
    logic [CH_W-1:0]     r_q   [0:QS-1][0:NUM_CH-1];

    assign c_inv = i_seg.den - i_seg.num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld <= 1'b0;
        end else if (i_en) begin
            r_mvld <= i_seg.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mdeg <= i_seg.degen;
            r_mden <= i_seg.den;
            for (int c = 0; c < NUM_CH; c++) begin
                r_prod[c] <= PROD_W'(i_seg.c0[c]) * PROD_W'(c_inv)
                             + PROD_W'(i_seg.c1[c]) * PROD_W'(i_seg.num);
            end
        end
    end

    // one quotient bit per stage, msb first
    for (genvar j = 0; j < QS; j++) begin : g_div
        logic [DIVD_W-1:0] c_in  [0:NUM_CH-1];
        logic [CH_W-1:0]   c_qin [0:NUM_CH-1];
        logic [DIVS_W-1:0] c_dvs;
        logic [DIVD_W-1:0] c_sub;
        logic              c_vin;
        logic              c_din;

        if (j == 0) begin : g_first
            always_comb begin
                c_vin = r_mvld;
                c_din = r_mdeg;
                c_dvs = {r_mden, 1'b0};
                for (int c = 0; c < NUM_CH; c++) begin
                    c_in[c]  = {r_prod[c], 1'b0} + DIVD_W'(r_mden);
                    c_qin[c] = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                c_vin = r_vld[j-1];
                c_din = r_deg[j-1];
                c_dvs = r_dvs[j-1];
                for (int c = 0; c < NUM_CH; c++) begin
                    c_in[c]  = r_rem[j-1][c];
                    c_qin[c] = r_q[j-1][c];
                end
            end
        end

        assign c_sub = DIVD_W'(c_dvs) << (QS - 1 - j);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= c_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_deg[j] <= c_din;
                r_dvs[j] <= c_dvs;
                for (int c = 0; c < NUM_CH; c++) begin
                    if (c_in[c] >= c_sub) begin
                        r_rem[j][c] <= c_in[c] - c_sub;
                        r_q[j][c]   <= c_qin[c] | CH_W'(1 << (QS - 1 - j));
                    end else begin
                        r_rem[j][c] <= c_in[c];
                        r_q[j][c]   <= c_qin[c];
                    end
                end
            end
        end
    end

    always_comb begin
        o_res.valid = r_vld[QS-1];
        o_res.degen = r_deg[QS-1];
        for (int c = 0; c < NUM_CH; c++) begin
            o_res.color[c] = r_q[QS-1][c];
        end
    end

endmodule

@@ rtl/colormap_linear_interpolate.sv @@
// top level of the piecewise-linear rgba color map
// a lookup result passes the input, point read, segment, product and divider registers
// throughput: one item per cycle, write or lookup, when the output is not stalled
// the pipeline holds in place while a result waits; in ready follows the output side
// reset: synchronous active low, clears valid bits and sets num_points to 2
// control point storage is not cleared and holds nothing until written
module colormap_linear_interpolate
    import cml_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [NPT_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_req_type,
    input  logic [IDX_W-1:0] i_point_index,
    input  logic [POS_W-1:0] i_point_pos,
    input  logic [CH_W-1:0]  i_point_red,
    input  logic [CH_W-1:0]  i_point_green,
    input  logic [CH_W-1:0]  i_point_blue,
    input  logic [CH_W-1:0]  i_point_alpha,
    input  logic [POS_W-1:0] i_lookup_pos,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [CH_W-1:0]  o_out_red,
    output logic [CH_W-1:0]  o_out_green,
    output logic [CH_W-1:0]  o_out_blue,
    output logic [CH_W-1:0]  o_out_alpha,
    output logic             o_degenerate_segment
);

    logic [NPT_W-1:0] r_npts;
    logic             w_en;
    t_req             w_req;
    t_seg             w_seg;
    t_res             w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_npts <= NPT_RESET;
        end else if (i_cfg_we) begin
            r_npts <= i_cfg_wdata;
        end
    end

    assign w_en = !w_res.valid || i_out_ready;

    always_comb begin
        w_req.req_type    = i_req_type;
        w_req.point_index = i_point_index;
        w_req.point_pos   = i_point_pos;
        w_req.color[0]    = i_point_red;
        w_req.color[1]    = i_point_green;
        w_req.color[2]    = i_point_blue;
        w_req.color[3]    = i_point_alpha;
        w_req.lookup_pos  = i_lookup_pos;
    end

    cml_seg #(.MAX_POINTS(MAX_POINTS)) u_seg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (i_in_valid),
        .i_req        (w_req),
        .i_num_points (r_npts),
        .o_seg        (w_seg)
    );

    cml_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_seg   (w_seg),
        .o_res   (w_res)
    );

    assign o_in_ready           = w_en;
    assign o_out_valid          = w_res.valid;
    assign o_out_red            = w_res.color[0];
    assign o_out_green          = w_res.color[1];
    assign o_out_blue           = w_res.color[2];
    assign o_out_alpha          = w_res.color[3];
    assign o_degenerate_segment = w_res.degen;

endmodule

@@ rtl/cml_checker.sv @@
// port-level assertions for the color map, bound to the top level
module cml_checker
    import cml_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [CH_W-1:0]  o_out_red,
    input logic [CH_W-1:0]  o_out_green,
    input logic [CH_W-1:0]  o_out_blue,
    input logic [CH_W-1:0]  o_out_alpha,
    input logic             o_degenerate_segment
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable({o_out_red, o_out_green, o_out_blue,
                                                 o_out_alpha, o_degenerate_segment}))
        else $error("result changed while stalled");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind colormap_linear_interpolate cml_checker u_cml_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_in_ready           (o_in_ready),
    .o_out_valid          (o_out_valid),
    .i_out_ready          (i_out_ready),
    .o_out_red            (o_out_red),
    .o_out_green          (o_out_green),
    .o_out_blue           (o_out_blue),
    .o_out_alpha          (o_out_alpha),
    .o_degenerate_segment (o_degenerate_segment)
);
